### rtl/core/rog_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radius of gyration package
// Shared widths, status codes, the atom record type and the divider types.
// ----------------------------------------------------------------------------
package rog_pkg;

  localparam int MAX_ATOMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_ATOMS);
  localparam int CNT_W     = $clog2(MAX_ATOMS + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0]        mass;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } atom_t;

  // Divider request and reply between the top level and the division unit.
  typedef struct packed {
    logic        start;
    logic        signed_mode;
    logic [65:0] dividend;
    logic [25:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [65:0] quotient;
  } div_rsp_t;

endpackage

### rtl/core/rog_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radius of gyration divider
// Restoring divider, one quotient bit per cycle. In signed mode the dividend
// is two's complement and the quotient is floored.
// ----------------------------------------------------------------------------
module rog_div (
  input  logic              clk,
  input  logic              rst,
  input  rog_pkg::div_req_t req,
  output rog_pkg::div_rsp_t rsp
);
  import rog_pkg::*;

  logic        busy;
  logic [6:0]  step;
  logic        neg;
  logic [65:0] quo;
  logic [25:0] rem;
  logic [25:0] dvs;
  logic [26:0] trial;
  logic [26:0] shifted;
  logic        done;

  assign shifted = {rem, quo[65]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 7'd66;
        neg  <= req.signed_mode & req.dividend[65];
        // Floor for negatives: q = -ceil(|a|/b) = ~((~a)/b) on the bitwise inverse.
        quo  <= (req.signed_mode & req.dividend[65]) ? ~req.dividend : req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (!trial[26]) begin
          rem <= trial[25:0];
          quo <= {quo[64:0], 1'b1};
        end else begin
          rem <= shifted[25:0];
          quo <= {quo[64:0], 1'b0};
        end
        step <= step - 7'd1;
        if (step == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? ~quo : quo;

endmodule

### rtl/core/radius_of_gyration_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radius of gyration unit
// Mass-weighted radius of gyration of one frame of atoms, in fixed point.
// ----------------------------------------------------------------------------
// Input requests carry one atom: tdata holds mass, x, y, z and frame time,
// tlast marks the final atom of the frame. Atoms load at one per cycle.
// On the last atom the unit computes the three center coordinates with a
// shared bit-serial divider, walks the atom memory with a four-stage
// pipeline at one atom per cycle followed by a drain, divides the spread
// by the total mass and takes a bit-serial square root. A frame with zero
// mass or too many atoms skips these steps and goes from its last atom
// straight to the output register. One result request leaves per frame
// with radius, frame stamp and status from an output register; the next
// frame loads and computes while it waits, and only the hand-over of the
// next result stalls until the receiver takes the waiting one. No atom is
// accepted while a frame is being computed. Reset clears the frame state;
// the atom memory holds no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module radius_of_gyration_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mass[15:0], x[39:16], y[63:40], z[87:64], frame_time[119:88]
  input  logic [119:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // radius[23:0], frame_stamp[55:24], status[57:56], zero fill
  output logic [63:0]  m_axis_tdata
);
  import rog_pkg::*;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b00000001,
    S_DIV   = 8'b00000010,
    S_WALK  = 8'b00000100,
    S_DRAIN = 8'b00001000,
    S_MDIV  = 8'b00010000,
    S_SQRT  = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_ISSUE = 8'b10000000
  } state_t;

  state_t state;

  atom_t mem [MAX_ATOMS];
  atom_t rd_atom;
  atom_t in_atom;
  logic [ADDR_W-1:0] rd_addr;

  logic [CNT_W-1:0]  atom_count;
  logic [25:0]       mass_total;
  logic signed [49:0] moment_x, moment_y, moment_z;
  logic [63:0]       spread_sum;
  logic              sat;
  logic [31:0]       held_time;
  logic              overflowed;
  logic [1:0]        axis;
  logic signed [25:0] cx, cy, cz;
  logic [CNT_W-1:0]  walk_idx;
  logic              v1, v2, v3, v4;
  logic [15:0]       m2, m3;
  logic [49:0]       s2;
  logic [65:0]       p3;
  logic [63:0]       sq_rem;
  logic [31:0]       sq_res;
  logic [5:0]        sq_step;
  logic [23:0]       radius_next;
  status_t           status;

  div_req_t dreq;
  div_rsp_t drsp;

  rog_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_atom.mass = s_axis_tdata[15:0];
  assign in_atom.x    = s_axis_tdata[39:16];
  assign in_atom.y    = s_axis_tdata[63:40];
  assign in_atom.z    = s_axis_tdata[87:64];

  logic accept;
  assign s_axis_tready = (state == S_LOAD);
  assign accept        = s_axis_tvalid & s_axis_tready;

  logic store_ok;
  assign store_ok = (atom_count != CNT_W'(MAX_ATOMS));

  logic signed [40:0] prod_x, prod_y, prod_z;
  assign prod_x = $signed({1'b0, in_atom.mass}) * in_atom.x;
  assign prod_y = $signed({1'b0, in_atom.mass}) * in_atom.y;
  assign prod_z = $signed({1'b0, in_atom.mass}) * in_atom.z;

  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      mem[atom_count[ADDR_W-1:0]] <= in_atom;
    end
    rd_atom <= mem[rd_addr];
  end

  assign rd_addr = walk_idx[ADDR_W-1:0];

  // Walk pipeline: stage 2 squares, stage 3 squared distance, stage 4 weighted product.
  logic signed [26:0] dx, dy, dz;
  logic [25:0] ax, ay, az;
  assign dx = 27'(rd_atom.x) - 27'(cx);
  assign dy = 27'(rd_atom.y) - 27'(cy);
  assign dz = 27'(rd_atom.z) - 27'(cz);
  assign ax = dx[26] ? 26'(-dx) : dx[25:0];
  assign ay = dy[26] ? 26'(-dy) : dy[25:0];
  assign az = dz[26] ? 26'(-dz) : dz[25:0];

  logic [51:0] sqx, sqy, sqz;
  logic [64:0] acc_sum;
  assign acc_sum = {1'b0, spread_sum} + {1'b0, p3[63:0]};

  logic [65:0] mom_sel;
  assign mom_sel = (axis == 2'd0) ? 66'(moment_x) :
                   (axis == 2'd1) ? 66'(moment_y) : 66'(moment_z);

  logic [63:0] sq_trial;
  logic [63:0] sq_bit;
  assign sq_bit   = 64'd1 << {sq_step[4:0], 1'b0};
  assign sq_trial = ({32'd0, sq_res} << (sq_step + 6'd1)) + sq_bit;

  assign radius_next = (status != ST_OK) ? 24'd0 :
                       (sat || sq_res[31:24] != '0) ? 24'hFFFFFF : sq_res[23:0];

  logic out_load;
  assign out_load = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    sqx <= ax * ax;
    sqy <= ay * ay;
    sqz <= az * az;
    m2  <= rd_atom.mass;
    m3  <= m2;
    s2  <= 50'(sqx) + 50'(sqy) + 50'(sqz);
    p3  <= 66'(s2) * 66'(m3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      atom_count    <= '0;
      mass_total    <= '0;
      moment_x      <= '0;
      moment_y      <= '0;
      moment_z      <= '0;
      spread_sum    <= '0;
      sat           <= 1'b0;
      held_time     <= '0;
      overflowed    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      dreq.start    <= 1'b0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      walk_idx      <= '0;
      axis          <= '0;
    end else begin
      dreq.start <= 1'b0;
      v2 <= v1 & (state == S_WALK || state == S_DRAIN);
      v3 <= v2;
      v4 <= v3;
      v1 <= 1'b0;
      m_axis_tvalid <= out_load | (m_axis_tvalid & ~m_axis_tready);
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (atom_count == '0 && !overflowed) begin
              held_time <= s_axis_tdata[119:88];
            end
            if (!store_ok) begin
              overflowed <= 1'b1;
            end else begin
              atom_count <= atom_count + 1'b1;
              mass_total <= mass_total + 26'(in_atom.mass);
              moment_x   <= moment_x + 50'(prod_x);
              moment_y   <= moment_y + 50'(prod_y);
              moment_z   <= moment_z + 50'(prod_z);
            end
            if (s_axis_tlast) begin
              if (overflowed || !store_ok) begin
                status <= ST_OVERFLOW; state <= S_OUT;
              end else if ((mass_total + 26'(in_atom.mass)) == '0) begin
                status <= ST_ZERO; state <= S_OUT;
              end else begin
                axis <= 2'd0; state <= S_ISSUE;
              end
            end
          end
        end
        S_ISSUE: begin
          // Numerator 2*moment + M over M; the halving afterwards supplies 2*M.
          dreq.start       <= 1'b1;
          dreq.signed_mode <= 1'b1;
          dreq.dividend    <= (mom_sel << 1) + 66'(mass_total);
          dreq.divisor     <= mass_total;
          state            <= S_DIV;
        end
        S_DIV: begin
          if (drsp.done) begin
            // Quotient of (2m+M)/M, floor then halve gives floor((2m+M)/(2M)).
            case (axis)
              2'd0: cx <= 26'($signed(drsp.quotient) >>> 1);
              2'd1: cy <= 26'($signed(drsp.quotient) >>> 1);
              default: cz <= 26'($signed(drsp.quotient) >>> 1);
            endcase
            if (axis == 2'd2) begin
              walk_idx <= '0;
              state    <= S_WALK;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_ISSUE;
            end
          end
        end
        S_WALK: begin
          v1       <= 1'b1;
          walk_idx <= walk_idx + 1'b1;
          if (walk_idx == atom_count - 1'b1) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!v1 && !v2 && !v3 && !v4) begin
            dreq.start       <= 1'b1;
            dreq.signed_mode <= 1'b0;
            dreq.dividend    <= {2'b00, spread_sum};
            dreq.divisor     <= mass_total;
            state            <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (drsp.done) begin
            sq_rem  <= drsp.quotient[63:0];
            sq_res  <= '0;
            sq_step <= 6'd31;
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_trial <= sq_rem) begin
            sq_rem <= sq_rem - sq_trial;
            sq_res <= sq_res | (32'd1 << sq_step[4:0]);
          end
          sq_step <= sq_step - 6'd1;
          if (sq_step == 6'd0) state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            m_axis_tdata <= {6'd0, status, held_time, radius_next};
            atom_count <= '0; mass_total <= '0;
            moment_x <= '0; moment_y <= '0; moment_z <= '0;
            spread_sum <= '0; sat <= 1'b0; held_time <= '0;
            overflowed <= 1'b0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
      if (state == S_ISSUE && axis == 2'd0) status <= ST_OK;
      if (v4) begin
        if (p3[65:64] != 2'b00 || acc_sum[64]) begin
          sat <= 1'b1; spread_sum <= '1;
        end else begin
          spread_sum <= acc_sum[63:0];
        end
      end
    end
  end

  a_ready_only_load: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == S_LOAD) else $error("ready outside load");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    atom_count <= CNT_W'(MAX_ATOMS)) else $error("atom count beyond memory");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result changed");

endmodule
